FILE: hw/rtl/tpou_pkg.sv
// Package for the tissue patch oxygen update unit.
// Field widths, thresholds, register indexes, drop codes and pipeline types.
// No dependencies; every other file refers to it by scoped names.
package tpou_pkg;

  localparam int OXY_W   = 14;
  localparam int LEVEL_W = 24;
  localparam int CYTO_W  = 16;
  localparam int COUNT_W = 16;
  localparam int GAIN_W  = 14;
  localparam int CODE_W  = 2;
  localparam int OXYD_W  = 18;  // signed oxygen after cytotoxic damage

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 104;

  // Pipeline depth: two front stages plus three gain steps of three stages.
  localparam int NSTAGE = 11;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] CFG_IDX_HEAL     = 2'd0;
  localparam logic [1:0] CFG_IDX_PAF_GAIN = 2'd1;
  localparam logic [1:0] CFG_IDX_IL8_GAIN = 2'd2;

  // Neighbour drop codes.
  localparam logic [CODE_W-1:0] DROP_NONE     = 2'd0;
  localparam logic [CODE_W-1:0] DROP_ISCHEMIA = 2'd1;
  localparam logic [CODE_W-1:0] DROP_INFARCT  = 2'd2;
  localparam logic [CODE_W-1:0] DROP_BOTH     = 2'd3;

  localparam logic [23:0]          ENDO_THRESHOLD = 24'd100;
  localparam logic [OXY_W-1:0]     OXY_ACTIVATE   = 14'd6000;
  localparam logic signed [OXYD_W-1:0] OXY_ISCHEMIA = 18'sd6000;
  localparam logic signed [OXYD_W-1:0] OXY_INFARCT  = 18'sd3000;
  // Ischemia drop of 50 pulls 3001..3050 into the infarct band as well.
  localparam logic signed [OXYD_W-1:0] OXY_BOTH_BANDS = 18'sd3050;
  localparam logic signed [OXYD_W-1:0] ISCHEMIA_DROP  = 18'sd50;
  localparam logic signed [OXYD_W-1:0] INFARCT_DROP   = 18'sd200;
  localparam logic [14:0]          OXY_FULL       = 15'd10000;

  localparam logic [GAIN_W-1:0]  GAIN_UNIT  = 14'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 24'hFFFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [30:0]        RECIP_100   = 31'd1374389535;
  localparam int                 RECIP_SHIFT = 37;

  typedef struct packed {
    logic signed [OXYD_W-1:0] oxy_d;
    logic [LEVEL_W-1:0]       paf;
    logic [LEVEL_W-1:0]       il8;
    logic [COUNT_W-1:0]       roll;
    logic [COUNT_W-1:0]       stick;
    logic                     active;
  } front_t;

  typedef struct packed {
    logic [OXY_W-1:0]   oxy;
    logic [LEVEL_W-1:0] il8;
    logic [COUNT_W-1:0] roll;
    logic [COUNT_W-1:0] stick;
    logic               active;
    logic               ischemia;
    logic               infarct;
  } side_t;

  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    count_up = (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

endpackage

FILE: hw/rtl/tpou_gain_pipe.sv
// Three-stage gain step for one level: scale (v + 100) by g/100 for small gains, add g otherwise.
// Uses tpou_pkg; stage load enables come from the top level's ready chain.
module tpou_gain_pipe (
  input  logic                           clk,
  input  logic [2:0]                     en,
  input  logic [tpou_pkg::LEVEL_W-1:0]   v_in,
  input  logic [tpou_pkg::GAIN_W-1:0]    gain,
  input  logic                           apply,
  output logic [tpou_pkg::LEVEL_W-1:0]   res
);

  // Stage a: v * g.
  logic [tpou_pkg::LEVEL_W-1:0] v_a_r;
  logic [tpou_pkg::GAIN_W-1:0]  g_a_r;
  logic                         apply_a_r;
  logic                         small_a_r;
  logic [30:0]                  prod_a_r;

  // Stage b: quotient by reciprocal and plain sum.
  logic [tpou_pkg::LEVEL_W-1:0] v_b_r;
  logic [tpou_pkg::GAIN_W-1:0]  g_b_r;
  logic                         apply_b_r;
  logic                         small_b_r;
  logic [24:0]                  quot_b_r;
  logic [24:0]                  sum_b_r;

  logic [tpou_pkg::LEVEL_W-1:0] res_r;
  logic [tpou_pkg::LEVEL_W-1:0] res_nxt;
  logic [61:0]                  recip_full;
  logic [25:0]                  scaled;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v_a_r     <= v_in;
      g_a_r     <= gain;
      apply_a_r <= apply;
      small_a_r <= (gain <= tpou_pkg::GAIN_UNIT);
      prod_a_r  <= {7'd0, v_in} * {24'd0, gain[6:0]};
    end
  end

  assign recip_full = {31'd0, prod_a_r} * {31'd0, tpou_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      v_b_r     <= v_a_r;
      g_b_r     <= g_a_r;
      apply_b_r <= apply_a_r;
      small_b_r <= small_a_r;
      quot_b_r  <= recip_full[61:tpou_pkg::RECIP_SHIFT];
      sum_b_r   <= {1'b0, v_a_r} + {11'd0, g_a_r};
    end
  end

  // (v + 100) * g / 100 equals floor(v * g / 100) + g since g is whole.
  assign scaled = {1'b0, quot_b_r} + {12'd0, g_b_r};

  always_comb begin
    if (!apply_b_r) begin
      res_nxt = v_b_r;
    end else if (small_b_r) begin
      res_nxt = (scaled[25:24] != 2'd0) ? tpou_pkg::LEVEL_MAX : scaled[23:0];
    end else begin
      res_nxt = sum_b_r[24] ? tpou_pkg::LEVEL_MAX : sum_b_r[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: hw/rtl/tissue_patch_oxygen_update_unit.sv
// Top level of the tissue patch oxygen update unit: stream in, stream out, APB config.
// Uses tpou_pkg and three plus one instances of tpou_gain_pipe.
//
// Usage
//   One tissue patch enters per transfer on the in_ stream and one updated patch
//   leaves per transfer on the out_ stream, in the same order. The block keeps no
//   patch state; the caller applies neighbour_drop to the eight neighbours.
//   The APB port holds the heal step and the PAF and IL8 gains at byte addresses
//   0, 4 and 8. Writes complete in the access cycle (pready is tied high), and they
//   are meant to happen while no patch is in flight.
// Pipeline
//   The pipeline has eleven register stages: two for activation, damage, healing
//   and the ischemia bands, then three gain steps of three stages each (multiply,
//   reciprocal multiply for the divide by 100, saturate). A patch can enter every
//   cycle as long as out_tready is high or some stage is still empty.
// Reset and stall
//   A synchronous low rst_n empties the pipeline and restores heal step 0 and gains
//   of 1.00. When the receiver holds out_tready low, each stage still fills if it is
//   empty, so input keeps flowing until every stage is occupied; nothing is dropped.
module tissue_patch_oxygen_update_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, lowest bit up: oxygen_level[13:0], endotoxin_level[37:14],
  // cytotoxicity[53:38], paf_level[77:54], il8_level[101:78],
  // rolling_count[117:102], sticking_count[133:118], is_active[134], zero pad[135].
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tpou_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata, lowest bit up: new_oxygen[13:0], new_paf[37:14], new_il8[61:38],
  // new_rolling[77:62], new_sticking[93:78], now_active[94],
  // neighbour_drop[96:95], zero pad[103:97].
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tpou_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [3:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int NS = tpou_pkg::NSTAGE;

  // ---------------------------------------------------------------- config
  logic [tpou_pkg::GAIN_W-1:0] heal_step_r;
  logic [tpou_pkg::GAIN_W-1:0] paf_gain_r;
  logic [tpou_pkg::GAIN_W-1:0] il8_gain_r;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heal_step_r <= '0;
      paf_gain_r  <= tpou_pkg::GAIN_UNIT;
      il8_gain_r  <= tpou_pkg::GAIN_UNIT;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        tpou_pkg::CFG_IDX_HEAL:     heal_step_r <= cfg_pwdata[13:0];
        tpou_pkg::CFG_IDX_PAF_GAIN: paf_gain_r  <= cfg_pwdata[13:0];
        tpou_pkg::CFG_IDX_IL8_GAIN: il8_gain_r  <= cfg_pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      tpou_pkg::CFG_IDX_HEAL:     cfg_prdata = {18'd0, heal_step_r};
      tpou_pkg::CFG_IDX_PAF_GAIN: cfg_prdata = {18'd0, paf_gain_r};
      tpou_pkg::CFG_IDX_IL8_GAIN: cfg_prdata = {18'd0, il8_gain_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- handshaking
  // Each stage loads when it is empty or its content moves on in the same cycle.
  logic [NS-1:0] valid_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !valid_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // ------------------------------------------------- stage 0: activation
  logic [13:0] in_oxy;
  logic [23:0] in_endo;
  logic [15:0] in_cyto;
  logic        in_act;
  logic        act_nxt;
  tpou_pkg::front_t front_nxt;
  tpou_pkg::front_t front_r;

  assign in_oxy  = in_tdata[13:0];
  assign in_endo = in_tdata[37:14];
  assign in_cyto = in_tdata[53:38];
  assign in_act  = in_tdata[134];
  assign act_nxt = in_act || (in_endo >= tpou_pkg::ENDO_THRESHOLD)
                   || (in_oxy < tpou_pkg::OXY_ACTIVATE);

  always_comb begin
    front_nxt.oxy_d  = $signed({4'd0, in_oxy}) - $signed({2'd0, in_cyto});
    front_nxt.paf    = in_tdata[77:54];
    front_nxt.il8    = in_tdata[101:78];
    front_nxt.roll   = act_nxt ? tpou_pkg::count_up(in_tdata[117:102]) : in_tdata[117:102];
    front_nxt.stick  = act_nxt ? tpou_pkg::count_up(in_tdata[133:118]) : in_tdata[133:118];
    front_nxt.active = act_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      front_r <= front_nxt;
    end
  end

  // ------------------------------------ stage 1: heal and ischemia bands
  logic                                 heal_zone;
  logic                                 isch;
  logic                                 infarct;
  logic [14:0]                          healed;
  logic signed [tpou_pkg::OXYD_W-1:0]   drop;
  logic signed [tpou_pkg::OXYD_W-1:0]   dropped;
  logic [tpou_pkg::OXY_W-1:0]           oxy_out;
  tpou_pkg::side_t                      side_nxt;
  tpou_pkg::side_t                      side_r [1:NS-1];
  logic [tpou_pkg::LEVEL_W-1:0]         paf1_r;

  assign heal_zone = front_r.oxy_d >= tpou_pkg::OXY_ISCHEMIA;
  assign isch      = !heal_zone && (front_r.oxy_d > tpou_pkg::OXY_INFARCT);
  assign infarct   = front_r.oxy_d <= tpou_pkg::OXY_BOTH_BANDS;
  // In the heal zone the damaged oxygen lies within 6000..16383.
  assign healed    = front_r.oxy_d[14:0] + {1'b0, heal_step_r};

  always_comb begin
    drop = '0;
    if (isch) begin
      drop = drop + tpou_pkg::ISCHEMIA_DROP;
    end
    if (infarct) begin
      drop = drop + tpou_pkg::INFARCT_DROP;
    end
  end

  assign dropped = front_r.oxy_d - drop;

  always_comb begin
    if (heal_zone) begin
      oxy_out = (healed > tpou_pkg::OXY_FULL) ? tpou_pkg::OXY_FULL[13:0] : healed[13:0];
    end else if (dropped[tpou_pkg::OXYD_W-1]) begin
      oxy_out = '0;
    end else begin
      // Below 6000 here, so fourteen bits hold it.
      oxy_out = dropped[13:0];
    end
  end

  always_comb begin
    side_nxt.oxy      = oxy_out;
    side_nxt.il8      = front_r.il8;
    side_nxt.roll     = isch ? tpou_pkg::count_up(front_r.roll) : front_r.roll;
    side_nxt.stick    = infarct ? tpou_pkg::count_up(front_r.stick) : front_r.stick;
    side_nxt.active   = front_r.active;
    side_nxt.ischemia = isch;
    side_nxt.infarct  = infarct;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      paf1_r <= front_r.paf;
    end
  end

  // --------------------------------------------------- gain step stages
  logic [tpou_pkg::LEVEL_W-1:0] paf_act;
  logic [tpou_pkg::LEVEL_W-1:0] paf_isch;
  logic [tpou_pkg::LEVEL_W-1:0] paf_inf;
  logic [tpou_pkg::LEVEL_W-1:0] il8_act;
  tpou_pkg::side_t              side_il8_joined;

  tpou_gain_pipe u_paf_act (
    .clk   (clk),
    .en    (rdy[4:2]),
    .v_in  (paf1_r),
    .gain  (paf_gain_r),
    .apply (side_r[1].active),
    .res   (paf_act)
  );

  tpou_gain_pipe u_il8_act (
    .clk   (clk),
    .en    (rdy[4:2]),
    .v_in  (side_r[1].il8),
    .gain  (il8_gain_r),
    .apply (side_r[1].active),
    .res   (il8_act)
  );

  tpou_gain_pipe u_paf_isch (
    .clk   (clk),
    .en    (rdy[7:5]),
    .v_in  (paf_act),
    .gain  (paf_gain_r),
    .apply (side_r[4].ischemia),
    .res   (paf_isch)
  );

  tpou_gain_pipe u_paf_inf (
    .clk   (clk),
    .en    (rdy[10:8]),
    .v_in  (paf_isch),
    .gain  (paf_gain_r),
    .apply (side_r[7].infarct),
    .res   (paf_inf)
  );

  // Side data rides alongside the gain stages; IL8 joins it once its step is done.
  always_comb begin
    side_il8_joined     = side_r[4];
    side_il8_joined.il8 = il8_act;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side_r[1] <= side_nxt;
    end
    for (int k = 2; k < NS; k++) begin
      if (rdy[k]) begin
        side_r[k] <= (k == 5) ? side_il8_joined : side_r[k-1];
      end
    end
  end

  // -------------------------------------------------------------- output
  tpou_pkg::side_t             side_out;
  logic [tpou_pkg::CODE_W-1:0] code;

  assign side_out = side_r[NS-1];

  always_comb begin
    case ({side_out.infarct, side_out.ischemia})
      2'b11:   code = tpou_pkg::DROP_BOTH;
      2'b10:   code = tpou_pkg::DROP_INFARCT;
      2'b01:   code = tpou_pkg::DROP_ISCHEMIA;
      default: code = tpou_pkg::DROP_NONE;
    endcase
  end

  assign out_tvalid = valid_r[NS-1];
  assign out_tdata  = {7'd0, code, side_out.active, side_out.stick, side_out.roll,
                       side_out.il8, paf_inf, side_out.oxy};

  // ---------------------------------------------------------- assertions
  a_accept_fills_front: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> valid_r[0])
    else $error("accepted patch did not enter the first stage");

  a_empty_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0] |-> in_tready)
    else $error("empty first stage refused a transfer");

  a_oxy_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13:0] <= 14'd10000)
    else $error("new_oxygen above full saturation");

  a_drop_low_oxy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[96:95] != tpou_pkg::DROP_NONE) |-> out_tdata[13:0] < 14'd5950)
    else $error("neighbour drop reported with oxygen outside the bands");

endmodule

FILE: tb/tpou_patch_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Patch item and result layouts plus the scoreboard for the patch oxygen update unit.
// Depends on tpou_pkg for widths, register indexes, drop codes and thresholds.
package tpou_patch_scoreboard_pkg;

  // Packed so that the last field sits in the lowest bits of tdata.
  typedef struct packed {
    logic                              pad;
    logic                              is_active;
    logic [tpou_pkg::COUNT_W-1:0]      sticking_count;
    logic [tpou_pkg::COUNT_W-1:0]      rolling_count;
    logic [tpou_pkg::LEVEL_W-1:0]      il8_level;
    logic [tpou_pkg::LEVEL_W-1:0]      paf_level;
    logic [tpou_pkg::CYTO_W-1:0]       cytotoxicity;
    logic [tpou_pkg::LEVEL_W-1:0]      endotoxin_level;
    logic [tpou_pkg::OXY_W-1:0]        oxygen_level;
  } patch_in_t;

  typedef struct packed {
    logic [6:0]                        pad;
    logic [tpou_pkg::CODE_W-1:0]       neighbour_drop;
    logic                              now_active;
    logic [tpou_pkg::COUNT_W-1:0]      new_sticking;
    logic [tpou_pkg::COUNT_W-1:0]      new_rolling;
    logic [tpou_pkg::LEVEL_W-1:0]      new_il8;
    logic [tpou_pkg::LEVEL_W-1:0]      new_paf;
    logic [tpou_pkg::OXY_W-1:0]        new_oxygen;
  } patch_out_t;

  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

  localparam int OXY_HEALTHY_MIN = 6000;
  localparam int OXY_INFARCT_MAX = 3000;
  localparam int OXY_CEILING     = 10000;
  localparam int ISCHEMIA_LOSS   = 50;
  localparam int INFARCT_LOSS    = 200;

  class patch_scoreboard;
    logic [tpou_pkg::GAIN_W-1:0] heal_step;
    logic [tpou_pkg::GAIN_W-1:0] paf_gain;
    logic [tpou_pkg::GAIN_W-1:0] il8_gain;
    patch_out_t                  expected_q[$];
    int                          errors;

    function new();
      heal_step = '0;
      paf_gain  = tpou_pkg::GAIN_UNIT;
      il8_gain  = tpou_pkg::GAIN_UNIT;
      errors    = 0;
    endfunction

    // Only the low 14 bits of the write data land in a register.
    function void set_reg(logic [1:0] idx, logic [31:0] word);
      case (idx)
        tpou_pkg::CFG_IDX_HEAL:     heal_step = word[tpou_pkg::GAIN_W-1:0];
        tpou_pkg::CFG_IDX_PAF_GAIN: paf_gain  = word[tpou_pkg::GAIN_W-1:0];
        tpou_pkg::CFG_IDX_IL8_GAIN: il8_gain  = word[tpou_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // A gain of 1.00 or less scales (v + 1.00), a larger gain is simply added.
    function logic [tpou_pkg::LEVEL_W-1:0] grown(logic [tpou_pkg::LEVEL_W-1:0] v,
                                                 logic [tpou_pkg::GAIN_W-1:0] g);
      logic [47:0] r;
      if (g <= tpou_pkg::GAIN_UNIT)
        r = (48'(v) + 48'd100) * 48'(g) / 48'd100;
      else
        r = 48'(v) + 48'(g);
      return (r > 48'(tpou_pkg::LEVEL_MAX)) ? tpou_pkg::LEVEL_MAX : r[23:0];
    endfunction

    function logic [tpou_pkg::COUNT_W-1:0] bumped(logic [tpou_pkg::COUNT_W-1:0] c);
      return (c == tpou_pkg::COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function patch_out_t updated_patch(patch_in_t p);
      patch_out_t r;
      int         oxy;
      logic       ischemic;
      logic       infarcted;
      r = '0;
      r.now_active = p.is_active || (p.endotoxin_level >= tpou_pkg::ENDO_THRESHOLD) ||
                     (p.oxygen_level < tpou_pkg::OXY_ACTIVATE);
      r.new_paf      = p.paf_level;
      r.new_il8      = p.il8_level;
      r.new_rolling  = p.rolling_count;
      r.new_sticking = p.sticking_count;
      if (r.now_active) begin
        r.new_rolling  = bumped(r.new_rolling);
        r.new_sticking = bumped(r.new_sticking);
        r.new_paf      = grown(r.new_paf, paf_gain);
        r.new_il8      = grown(r.new_il8, il8_gain);
      end
      oxy = int'(p.oxygen_level) - int'(p.cytotoxicity);
      if (oxy >= OXY_HEALTHY_MIN) begin
        oxy += int'(heal_step);
        if (oxy > OXY_CEILING) oxy = OXY_CEILING;
      end
      ischemic = (oxy < OXY_HEALTHY_MIN) && (oxy > OXY_INFARCT_MAX);
      if (ischemic) begin
        r.new_rolling = bumped(r.new_rolling);
        oxy -= ISCHEMIA_LOSS;
        r.new_paf = grown(r.new_paf, paf_gain);
      end
      // Evaluated after the ischemia drop, so both bands can fire together.
      infarcted = (oxy <= OXY_INFARCT_MAX);
      if (infarcted) begin
        r.new_sticking = bumped(r.new_sticking);
        oxy -= INFARCT_LOSS;
        r.new_paf = grown(r.new_paf, paf_gain);
      end
      if (oxy < 0) oxy = 0;
      r.new_oxygen = 14'(oxy);
      if (ischemic && infarcted)
        r.neighbour_drop = tpou_pkg::DROP_BOTH;
      else if (infarcted)
        r.neighbour_drop = tpou_pkg::DROP_INFARCT;
      else if (ischemic)
        r.neighbour_drop = tpou_pkg::DROP_ISCHEMIA;
      else
        r.neighbour_drop = tpou_pkg::DROP_NONE;
      return r;
    endfunction

    function void note_input(patch_in_t p);
      expected_q.insert(expected_q.size(), updated_patch(p));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void compare_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, actual %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(patch_out_t got);
      patch_out_t exp;
      if (expected_q.size() == 0) begin
        $error("result transfer arrived with no patch outstanding");
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("new_oxygen", exp.new_oxygen, got.new_oxygen);
      compare_field("new_paf", exp.new_paf, got.new_paf);
      compare_field("new_il8", exp.new_il8, got.new_il8);
      compare_field("new_rolling", exp.new_rolling, got.new_rolling);
      compare_field("new_sticking", exp.new_sticking, got.new_sticking);
      compare_field("now_active", exp.now_active, got.now_active);
      compare_field("neighbour_drop", exp.neighbour_drop, got.neighbour_drop);
      compare_field("zero pad", exp.pad, got.pad);
    endfunction
  endclass

endpackage

FILE: tb/tb_tissue_patch_oxygen_update_unit.sv
`timescale 1ns / 1ps
// Testbench for tissue_patch_oxygen_update_unit: directed and random patches,
// register settings and idling phases, checked by the patch scoreboard.
// Depends on tpou_pkg, tpou_patch_scoreboard_pkg and the unit's RTL.
module tb_tissue_patch_oxygen_update_unit;

  // The unit never goes this long without a transfer on one side or the other,
  // even while the receiver holds off on purpose.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 150;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  // in_tdata, lowest bit up: oxygen_level, endotoxin_level, cytotoxicity,
  // paf_level, il8_level, rolling_count, sticking_count, is_active, zero pad.
  logic [tpou_pkg::IN_DATA_W-1:0]      in_tdata = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  // out_tdata, lowest bit up: new_oxygen, new_paf, new_il8, new_rolling,
  // new_sticking, now_active, neighbour_drop, zero pad.
  logic [tpou_pkg::OUT_DATA_W-1:0]     out_tdata;
  logic                                cfg_psel = 1'b0;
  logic                                cfg_penable = 1'b0;
  logic                                cfg_pwrite = 1'b0;
  logic [3:0]                          cfg_paddr = '0;
  logic [31:0]                         cfg_pwdata = '0;
  logic [31:0]                         cfg_prdata;
  logic                                cfg_pready;

  tpou_patch_scoreboard_pkg::patch_scoreboard sb;

  // Idling percentages for the current phase, read by the sender task and the
  // receiver process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // The main thread bumps hold_requests; the receiver notices the change and
  // holds out_tready low while it counts hold_left down from HOLD_CYCLES.
  int hold_requests  = 0;
  int hold_granted   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  tissue_patch_oxygen_update_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: either a deliberate long hold-off, or random stalls at the phase's rate.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_granted != hold_requests) begin
        hold_granted = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every result transfer is checked against the oldest outstanding patch. Values
  // are read before this edge's updates land, so they are the ones the edge saw.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(tpou_patch_scoreboard_pkg::patch_out_t'(out_tdata));
  end

  // The watchdog counts cycles without any transfer and ends a hung run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // One patch transfer. Idle gaps come first, so valid is only lowered in a step
  // where it is not also raised; back-to-back patches keep valid high throughout.
  task automatic send_patch(tpou_patch_scoreboard_pkg::patch_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    sb.note_input(p);
  endtask

  // Drop valid and wait until every outstanding result has been checked. Each patch
  // yields exactly one result, so an empty scoreboard means an empty pipeline.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // APB write: setup cycle, access cycle, and the register is taken at the edge that
  // closes the access cycle. Upper data bits carry random junk half of the time,
  // which the unit must ignore.
  task automatic cfg_write(logic [1:0] idx, logic [tpou_pkg::GAIN_W-1:0] value);
    logic [31:0] word;
    word = {($urandom_range(1) != 0) ? 18'($urandom) : 18'd0, value};
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, word);
  endtask

  function automatic tpou_patch_scoreboard_pkg::patch_in_t mk_patch(
      int oxy, int endo, int cyto, int paf, int il8, int roll, int stick, bit act);
    tpou_patch_scoreboard_pkg::patch_in_t p;
    p = '0;
    p.oxygen_level    = 14'(oxy);
    p.endotoxin_level = 24'(endo);
    p.cytotoxicity    = 16'(cyto);
    p.paf_level       = 24'(paf);
    p.il8_level       = 24'(il8);
    p.rolling_count   = 16'(roll);
    p.sticking_count  = 16'(stick);
    p.is_active       = act;
    return p;
  endfunction

  function automatic logic [tpou_pkg::LEVEL_W-1:0] random_level();
    case ($urandom_range(2))
      0:       return 24'($urandom);
      1:       return tpou_pkg::LEVEL_MAX - 24'($urandom_range(20000));
      default: return 24'($urandom_range(1000));
    endcase
  endfunction

  function automatic logic [tpou_pkg::COUNT_W-1:0] random_count();
    case ($urandom_range(2))
      0:       return 16'($urandom);
      1:       return tpou_pkg::COUNT_MAX - 16'($urandom_range(3));
      default: return 16'($urandom_range(100));
    endcase
  endfunction

  // Random patch, weighted toward the activation, ischemia and infarction edges
  // while full-width draws still toggle every bit of every field but the zero pad.
  function automatic tpou_patch_scoreboard_pkg::patch_in_t random_patch();
    tpou_patch_scoreboard_pkg::patch_in_t p;
    p = '0;
    case ($urandom_range(7))
      0: p.oxygen_level = 14'($urandom);
      1: p.oxygen_level = 14'($urandom_range(10000));
      2: p.oxygen_level = 14'($urandom_range(6050, 5950));
      3: p.oxygen_level = 14'($urandom_range(3060, 2990));
      4: p.oxygen_level = 14'($urandom_range(300));
      5: p.oxygen_level = 14'($urandom_range(10000, 6000));
      6: p.oxygen_level = 14'($urandom_range(6000, 3000));
      default: p.oxygen_level = 14'(16383 - $urandom_range(400));
    endcase
    case ($urandom_range(3))
      0: p.cytotoxicity = '0;
      1: p.cytotoxicity = 16'($urandom_range(200));
      2: p.cytotoxicity = 16'($urandom_range(4000));
      default: p.cytotoxicity = 16'($urandom);
    endcase
    case ($urandom_range(2))
      0: p.endotoxin_level = 24'($urandom_range(99));
      1: p.endotoxin_level = 24'($urandom_range(110, 90));
      default: p.endotoxin_level = 24'($urandom);
    endcase
    p.paf_level      = random_level();
    p.il8_level      = random_level();
    p.rolling_count  = random_count();
    p.sticking_count = random_count();
    p.is_active      = 1'($urandom_range(1));
    return p;
  endfunction

  // One phase: registers written while idle, idling rates set, then random patches.
  task automatic run_phase(logic [13:0] heal, logic [13:0] pgain, logic [13:0] igain,
                           int idle_pct, int stall_pct, bit pressure, bit bad_write);
    drain();
    cfg_write(tpou_pkg::CFG_IDX_HEAL, heal);
    cfg_write(tpou_pkg::CFG_IDX_PAF_GAIN, pgain);
    cfg_write(tpou_pkg::CFG_IDX_IL8_GAIN, igain);
    // A write past the register list must leave every register as it was.
    if (bad_write) cfg_write(tpou_patch_scoreboard_pkg::CFG_IDX_UNUSED, 14'($urandom));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (pressure) hold_requests++;
    repeat (PHASE_ITEMS) send_patch(random_patch());
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed patches under the reset settings (heal 0, both gains 1.00).
    send_patch(mk_patch(0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_patch(mk_patch(16383, 16777215, 0, 16777215, 16777215, 65535, 65535, 1'b1));
    send_patch(mk_patch(10000, 99, 0, 500, 700, 3, 4, 1'b0));
    // Oxygen exactly at the activation threshold does not latch the patch.
    send_patch(mk_patch(6000, 99, 0, 123, 456, 7, 8, 1'b0));
    send_patch(mk_patch(5999, 0, 0, 1000, 2000, 10, 20, 1'b0));
    send_patch(mk_patch(8000, 100, 0, 0, 0, 0, 0, 1'b0));
    // The ischemia drop from 3001..3050 lands in the infarct band as well.
    send_patch(mk_patch(3050, 0, 0, 100, 100, 1, 1, 1'b0));
    send_patch(mk_patch(3051, 0, 0, 100, 100, 1, 1, 1'b0));
    send_patch(mk_patch(3001, 0, 0, 100, 100, 1, 1, 1'b0));
    send_patch(mk_patch(3000, 0, 0, 100, 100, 1, 1, 1'b0));
    // Deep infarction floors oxygen at zero.
    send_patch(mk_patch(100, 0, 0, 50, 60, 0, 0, 1'b1));
    send_patch(mk_patch(6000, 0, 1, 50, 60, 0, 0, 1'b0));
    send_patch(mk_patch(0, 0, 65535, 0, 0, 0, 0, 1'b0));
    send_patch(mk_patch(16383, 0, 0, 9, 9, 9, 9, 1'b0));
    send_patch(mk_patch(5000, 0, 0, 16777000, 16777215, 65534, 65534, 1'b1));
    send_patch(mk_patch(2000, 16777215, 65535, 16777215, 0, 65535, 65535, 1'b1));
    send_patch(mk_patch(9000, 0, 3000, 77, 88, 5, 6, 1'b1));

    // Register settings from the extremes to random ones, cycling the idling mixes.
    run_phase(14'd0, 14'd0, 14'd0, 0, 0, 1'b0, 1'b0);
    run_phase(14'h3FFF, 14'h3FFF, 14'h3FFF, 61, 0, 1'b0, 1'b0);
    run_phase(14'd10000, 14'd100, 14'd101, 0, 61, 1'b0, 1'b0);
    // The receiver holds off here while patches keep coming, filling the pipeline.
    run_phase(14'd50, 14'd101, 14'd100, 28, 28, 1'b1, 1'b0);
    run_phase(14'($urandom_range(10000)), 14'($urandom_range(200)),
              14'($urandom_range(200)), 0, 0, 1'b0, 1'b0);
    run_phase(14'($urandom), 14'($urandom), 14'($urandom), 61, 0, 1'b0, 1'b0);
    run_phase(14'd0, 14'd100, 14'd100, 0, 61, 1'b0, 1'b1);
    run_phase(14'($urandom_range(500)), 14'($urandom_range(10000)),
              14'($urandom_range(100)), 28, 28, 1'b0, 1'b0);

    // Let any stray extra result surface before the verdict.
    drain();
    repeat (4 * tpou_pkg::NSTAGE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tpou_pkg.sv
hw/rtl/tpou_gain_pipe.sv
hw/rtl/tissue_patch_oxygen_update_unit.sv
tb/tpou_patch_scoreboard_pkg.sv
tb/tb_tissue_patch_oxygen_update_unit.sv
